// ----- src/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int VAL_W     = 32;
    localparam int PRI_W     = 8;
    localparam int ENT_W     = VAL_W + PRI_W;
    localparam int CMD_W     = 2;
    localparam int CNT_OUT_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_CMP,
        S_PUSH_INS,
        S_POP_HEAD,
        S_POP_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] popped_value;
        logic             popped;
        logic             push_dropped;
    } t_result;

endpackage

// ----- src/spq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/spq_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_engine
// sequencer with one priority comparator that shifts entries one per cycle
// ----------------------------------------------------------------------------
module spq_engine #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [spq_pkg::CMD_W-1:0]     i_cmd,
    input  logic [spq_pkg::VAL_W-1:0]     i_value,
    input  logic [spq_pkg::PRI_W-1:0]     i_priority,
    output logic                          o_ram_we,
    output logic [$clog2(DEPTH)-1:0]      o_ram_waddr,
    output logic [spq_pkg::ENT_W-1:0]     o_ram_wdata,
    output logic [$clog2(DEPTH)-1:0]      o_ram_raddr,
    input  logic [spq_pkg::ENT_W-1:0]     i_ram_rdata,
    output logic                          o_done,
    input  logic                          i_out_free,
    output spq_pkg::t_result              o_res,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state           r_state, n_state;
    logic [AW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_count, n_count;
    logic [VAL_W-1:0] r_val, n_val;
    logic [PRI_W-1:0] r_pri, n_pri;
    logic [VAL_W-1:0] r_pop_val, n_pop_val;
    logic             r_popped, n_popped;
    logic             r_dropped, n_dropped;

    logic [CW-1:0]    w_cnt_m1;
    logic [AW-1:0]    w_last;
    logic             w_full;
    logic [PRI_W-1:0] w_rd_pri;
    logic [VAL_W-1:0] w_rd_val;

    assign w_cnt_m1 = r_count - CW'(1);
    assign w_last   = w_cnt_m1[AW-1:0];
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_rd_pri = i_ram_rdata[PRI_W-1:0];
    assign w_rd_val = i_ram_rdata[ENT_W-1:PRI_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx     <= n_idx;
        r_val     <= n_val;
        r_pri     <= n_pri;
        r_pop_val <= n_pop_val;
        r_popped  <= n_popped;
        r_dropped <= n_dropped;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_val       = r_val;
        n_pri       = r_pri;
        n_pop_val   = r_pop_val;
        n_popped    = r_popped;
        n_dropped   = r_dropped;
        o_ready     = 1'b0;
        o_done      = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx;
        o_ram_wdata = {r_val, r_pri};
        o_ram_raddr = r_idx;
        case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                o_ram_raddr = (i_cmd == CMD_POP) ? '0 : w_last;
                if (i_valid) begin
                    n_val     = i_value;
                    n_pri     = i_priority;
                    n_pop_val = '0;
                    n_popped  = 1'b0;
                    n_dropped = 1'b0;
                    n_state   = S_DONE;
                    case (i_cmd)
                        CMD_PUSH: begin
                            if (w_full) begin
                                n_dropped = 1'b1;
                            end else if (r_count == '0) begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = '0;
                                o_ram_wdata = {i_value, i_priority};
                                n_count     = r_count + CW'(1);
                            end else begin
                                n_idx   = w_last;
                                n_state = S_PUSH_CMP;
                            end
                        end
                        CMD_POP: begin
                            if (r_count != '0) begin
                                n_state = S_POP_HEAD;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_PUSH_CMP: begin
                o_ram_raddr = r_idx - AW'(1);
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx + AW'(1);
                if (w_rd_pri < r_pri) begin
                    o_ram_wdata = i_ram_rdata;
                    if (r_idx == '0) begin
                        n_state = S_PUSH_INS;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end
            end
            S_PUSH_INS: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = '0;
                n_count     = r_count + CW'(1);
                n_state     = S_DONE;
            end
            S_POP_HEAD: begin
                n_pop_val   = w_rd_val;
                n_popped    = 1'b1;
                o_ram_raddr = AW'(1);
                n_idx       = AW'(1);
                if (r_count == CW'(1)) begin
                    n_count = w_cnt_m1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_POP_SHIFT;
                end
            end
            S_POP_SHIFT: begin
                o_ram_raddr = r_idx + AW'(1);
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx - AW'(1);
                o_ram_wdata = i_ram_rdata;
                if (r_idx == w_last) begin
                    n_count = w_cnt_m1;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DONE: begin
                o_done = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.popped_value = r_pop_val;
    assign o_res.popped       = r_popped;
    assign o_res.push_dropped = r_dropped;
    assign o_count            = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_valid) |-> !o_ram_we)
        else $error("store written while idle");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_cmd == CMD_CLEAR) |=> (r_count == '0))
        else $error("clear left entries");

    a_done_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !(r_popped && r_dropped))
        else $error("pop and drop flagged together");

endmodule

// ----- src/sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps
// clear, unused command, empty pop and push when full or empty: the engine goes straight to its done state
// push: entries from the tail with lower priority move down one place each, then the new one is written
// pop: the head is read out, then the entries behind it move up one place each
// one operation at a time, paced by the one read, one write port store and its one comparator
// reset: synchronous, clears the count and the control state, store contents are kept
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// priority queue kept sorted in a ram, with a registered result stage
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [spq_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [spq_pkg::VAL_W-1:0]  i_push_value,
    input  logic [spq_pkg::PRI_W-1:0]         i_push_priority,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [spq_pkg::VAL_W-1:0]  o_popped_value,
    output logic                              o_popped,
    output logic                              o_push_dropped,
    output logic [spq_pkg::CNT_OUT_W-1:0]     o_entry_count,
    output logic                              o_is_empty,
    output logic                              o_is_full
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic             w_ram_we;
    logic [AW-1:0]    w_ram_waddr;
    logic [ENT_W-1:0] w_ram_wdata;
    logic [AW-1:0]    w_ram_raddr;
    logic [ENT_W-1:0] w_ram_rdata;
    logic             w_done;
    logic             w_out_free;
    t_result          w_res;
    logic [CW-1:0]    w_count;

    logic                 r_o_valid;
    logic [VAL_W-1:0]     r_popped_value;
    logic                 r_popped;
    logic                 r_push_dropped;
    logic [CNT_OUT_W-1:0] r_entry_count;
    logic                 r_is_empty;
    logic                 r_is_full;

    spq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    spq_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_value     (i_push_value),
        .i_priority  (i_push_priority),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_done      (w_done),
        .i_out_free  (w_out_free),
        .o_res       (w_res),
        .o_count     (w_count)
    );

    assign w_out_free = !r_o_valid || i_ready;

    // result stage, loaded when the previous result has gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_done && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
        if (w_done && w_out_free) begin
            r_popped_value <= w_res.popped_value;
            r_popped       <= w_res.popped;
            r_push_dropped <= w_res.push_dropped;
            r_entry_count  <= CNT_OUT_W'(w_count);
            r_is_empty     <= (w_count == '0);
            r_is_full      <= (w_count == CW'(DEPTH));
        end
    end

    assign o_valid        = r_o_valid;
    assign o_popped_value = r_popped_value;
    assign o_popped       = r_popped;
    assign o_push_dropped = r_push_dropped;
    assign o_entry_count  = r_entry_count;
    assign o_is_empty     = r_is_empty;
    assign o_is_full      = r_is_full;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted priority queue: a shadow copy of the
// sorted store predicts the status of every transfer, and random idling is
// applied on both the command and the result side
// ----------------------------------------------------------------------------
module tb_top;
    import spq_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int BLOCK_OPS = 48;
    localparam int RANDOM_OPS = 1150;
    localparam int SETTLE_CYCLES = DEPTH + 8;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic signed [VAL_W-1:0] popped_value;
        logic                    popped;
        logic                    push_dropped;
        logic [CNT_OUT_W-1:0]    entry_count;
        logic                    is_empty;
        logic                    is_full;
    } t_status;

    class queue_shadow;
        logic signed [VAL_W-1:0] vals [DEPTH];
        logic [PRI_W-1:0]        pris [DEPTH];
        int                      held;
        t_status                 owed [$];
        int                      mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function void note_op(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] value,
                              logic [PRI_W-1:0] pri);
            t_status s;
            int pos;
            s.popped_value = '0;
            s.popped = 1'b0;
            s.push_dropped = 1'b0;
            case (cmd)
                CMD_PUSH: begin
                    if (held >= DEPTH) begin
                        s.push_dropped = 1'b1;
                    end else begin
                        // new entry goes behind every entry of equal or higher priority
                        pos = held;
                        for (int i = held - 1; i >= 0; i--) begin
                            if (pris[i] < pri) pos = i;
                        end
                        for (int i = held; i > pos; i--) begin
                            vals[i] = vals[i-1];
                            pris[i] = pris[i-1];
                        end
                        vals[pos] = value;
                        pris[pos] = pri;
                        held++;
                    end
                end
                CMD_POP: begin
                    if (held > 0) begin
                        s.popped_value = vals[0];
                        s.popped = 1'b1;
                        for (int i = 0; i + 1 < held; i++) begin
                            vals[i] = vals[i+1];
                            pris[i] = pris[i+1];
                        end
                        held--;
                    end
                end
                CMD_CLEAR: begin
                    held = 0;
                end
                default: begin
                end
            endcase
            s.entry_count = CNT_OUT_W'(held);
            s.is_empty = (held == 0);
            s.is_full = (held == DEPTH);
            owed.push_back(s);
        endfunction

        function void check_result(t_status got);
            t_status want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer at %0t", $realtime);
            end else begin
                want = owed.pop_front();
                if (got.popped_value !== want.popped_value || got.popped !== want.popped ||
                    got.push_dropped !== want.push_dropped ||
                    got.entry_count !== want.entry_count ||
                    got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: exp val %0d pop %0b drop %0b cnt %0d %s",
                                 $realtime, want.popped_value, want.popped,
                                 want.push_dropped, want.entry_count, "");
                        $display("  exp emp %0b full %0b", want.is_empty, want.is_full);
                        $display("  got val %0d pop %0b drop %0b cnt %0d emp %0b full %0b",
                                 got.popped_value, got.popped, got.push_dropped,
                                 got.entry_count, got.is_empty, got.is_full);
                    end
                end
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [CMD_W-1:0]        i_cmd;
    logic signed [VAL_W-1:0] i_push_value;
    logic [PRI_W-1:0]        i_push_priority;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [VAL_W-1:0] o_popped_value;
    logic                    o_popped;
    logic                    o_push_dropped;
    logic [CNT_OUT_W-1:0]    o_entry_count;
    logic                    o_is_empty;
    logic                    o_is_full;

    queue_shadow shadow;
    logic        calm_tx;
    int          cycles = 0;

    sorted_priority_queue_top #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_push_value    (i_push_value),
        .i_push_priority (i_push_priority),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_popped_value  (o_popped_value),
        .o_popped        (o_popped),
        .o_push_dropped  (o_push_dropped),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_is_full       (o_is_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_op(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] value,
                           input logic [PRI_W-1:0] pri);
        int gap;
        gap = (calm_tx || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_push_value <= value;
        i_push_priority <= pri;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        shadow.note_op(cmd, value, pri);
    endtask

    initial begin : receiver
        int stall;
        logic calm_rx;
        stall = 0;
        calm_rx = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 199) == 0) calm_rx = !calm_rx;
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!calm_rx && $urandom_range(0, 3) == 0) stall = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        t_status got;
        if (i_rst_n && o_valid && i_ready) begin
            got.popped_value = o_popped_value;
            got.popped = o_popped;
            got.push_dropped = o_push_dropped;
            got.entry_count = o_entry_count;
            got.is_empty = o_is_empty;
            got.is_full = o_is_full;
            shadow.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        int mode;
        int share;
        int r;
        logic [CMD_W-1:0] cmd;
        logic signed [VAL_W-1:0] value;
        logic [PRI_W-1:0] pri;
        shadow = new();
        calm_tx = 1'b1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_PUSH;
        i_push_value = '0;
        i_push_priority = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pop, unused command, extremes, ties, clear, full queue
        send_op(CMD_POP, 32'sh1234_5678, 8'hFF);
        send_op(CMD_UNUSED, -32'sd1, 8'hFF);
        send_op(CMD_PUSH, 32'sh7FFF_FFFF, 8'h00);
        send_op(CMD_PUSH, 32'sh8000_0000, 8'hFF);
        send_op(CMD_PUSH, -32'sd1, 8'hFF);
        send_op(CMD_PUSH, 32'sd0, 8'h00);
        send_op(CMD_POP, 32'sd0, 8'h00);
        send_op(CMD_CLEAR, 32'sd0, 8'h00);
        send_op(CMD_POP, 32'sd0, 8'h00);
        for (int i = 0; i < DEPTH; i++)
            send_op(CMD_PUSH, VAL_W'(i * 32'h1111_1111), PRI_W'((i % 4) * 85));
        send_op(CMD_PUSH, 32'sh5555_AAAA, 8'hFF);
        send_op(CMD_CLEAR, 32'sd0, 8'h00);

        // random: blocks biased towards filling, draining or balanced traffic
        for (int b = 0; b * BLOCK_OPS < RANDOM_OPS; b++) begin
            mode = $urandom_range(0, 2);
            share = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
            calm_tx = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < BLOCK_OPS; k++) begin
                r = $urandom_range(0, 99);
                if (r < share) cmd = CMD_PUSH;
                else if (r < 95) cmd = CMD_POP;
                else if (r < 98) cmd = CMD_CLEAR;
                else cmd = CMD_UNUSED;
                if ($urandom_range(0, 9) == 0)
                    value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                else
                    value = $urandom;
                if ($urandom_range(0, 1) == 0) pri = PRI_W'($urandom_range(0, 3) * 85);
                else pri = PRI_W'($urandom_range(0, 255));
                send_op(cmd, value, pri);
            end
        end
        i_valid <= 1'b0;

        while (shadow.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (shadow.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
